// ----- hdl/bssp_pkg.sv -----
package bssp_pkg;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_COUNT   = 2'd2,
		PH_RECORDS = 2'd3
	} phase_t;

	localparam logic [2:0] KIND_NORMAL = 3'd0;
	localparam logic [2:0] KIND_BOXMIN = 3'd4;
	localparam logic [2:0] KIND_BOXMAX = 3'd5;
	localparam logic [2:0] KIND_TRUNC  = 3'd6;

	localparam logic [6:0] HEADER_BYTES = 7'd80;
	localparam logic [6:0] VEC_BYTES    = 7'd48;
	localparam logic [6:0] RECORD_LAST  = 7'd49;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] idx;
		logic        last;
	} res_t;

	// Strict float a < b on raw single bits; false when either is NaN.
	function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
		logic a_nan, b_nan, r;
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		if (a_nan || b_nan)
			r = 1'b0;
		else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0))
			r = 1'b0;
		else if (a[31] != b[31])
			r = a[31];
		else if (a[31])
			r = a[30:0] > b[30:0];
		else
			r = a[30:0] < b[30:0];
		return r;
	endfunction

endpackage

// ----- hdl/bssp_box.sv -----
module bssp_box import bssp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clr,
	input  logic        upd,
	input  logic [31:0] vx,
	input  logic [31:0] vy,
	input  logic [31:0] vz,
	output logic [95:0] lo,
	output logic [95:0] hi
);
	logic        started_q;
	logic [95:0] lo_q, hi_q, v;

	assign v  = {vz, vy, vx};
	assign lo = lo_q;
	assign hi = hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
		end else if (clr) begin
			started_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
		end else if (upd) begin
			started_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				if (!started_q || f_lt(v[i*32 +: 32], lo_q[i*32 +: 32]))
					lo_q[i*32 +: 32] <= v[i*32 +: 32];
				if (!started_q || f_lt(hi_q[i*32 +: 32], v[i*32 +: 32]))
					hi_q[i*32 +: 32] <= v[i*32 +: 32];
			end
		end
	end
endmodule

// ----- hdl/bssp_outq.sv -----
module bssp_outq import bssp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [1:0] n_in,
	input  res_t r0,
	input  res_t r1,
	output logic space,
	output logic m_tvalid,
	input  logic m_tready,
	output res_t head
);
	// 4-entry FIFO; up to two results written per transfer
	res_t        mem_q [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;
	logic        pop;

	assign m_tvalid = cnt_q != 3'd0;
	assign head     = mem_q[rp_q];
	assign pop      = m_tvalid && m_tready;
	assign space    = cnt_q <= 3'd2;

	always_ff @(posedge clk) begin
		if (push && n_in != 2'd0) begin
			mem_q[wp_q] <= r0;
			if (n_in == 2'd2)
				mem_q[wp_q + 2'd1] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + n_in;
			if (pop)
				rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + (push ? {1'b0, n_in} : 3'd0) - {2'b0, pop};
		end
	end
endmodule

// ----- hdl/binary_stl_stream_parser_top.sv -----
// Each result is written to the result FIFO on the byte transfer causing it.
// Throughput: one byte per cycle; a byte causing two results queues both,
// and input stalls when the 4-entry result FIFO lacks room for two.
// Reset (arst_n low, asynchronous): parser idle, counters, box and FIFO cleared.
module binary_stl_stream_parser_top import bssp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tuser,   // start_of_file
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // x_bits, y_bits, z_bits, triangle_index
	output logic [2:0]   m_tuser,   // kind
	output logic         m_tlast    // last_of_run
);
	phase_t      phase_q, ph;
	logic [6:0]  pos_q;
	logic [23:0] part_q;
	logic [31:0] hx_q, hy_q, total_q, done_q;
	logic        acc, sof, box_upd;
	logic [31:0] word;
	logic [1:0]  k;
	logic [95:0] lo, hi;
	logic [1:0]  n;
	res_t        r0, r1, head;
	logic [3:0]  wi;
	logic [1:0]  comp, vec;
	logic        restart_mid;
	logic        vec_out, fin;

	assign acc  = s_tvalid && s_tready;
	assign sof  = s_tuser;
	assign k    = pos_q[1:0];
	assign word = {s_tdata, part_q};
	assign wi   = pos_q[5:2];
	always_comb begin
		unique case (wi)
			4'd0, 4'd3, 4'd6, 4'd9:  comp = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10: comp = 2'd1;
			default:                 comp = 2'd2;
		endcase
		vec = (wi < 4'd3) ? 2'd0 : (wi < 4'd6) ? 2'd1 : (wi < 4'd9) ? 2'd2 : 2'd3;
	end

	assign ph = sof ? PH_HEADER : phase_q;
	assign restart_mid = sof && phase_q != PH_IDLE;
	assign vec_out = ph == PH_RECORDS && !sof && pos_q < VEC_BYTES && k == 2'd3
		&& comp == 2'd2;
	assign fin = ph == PH_RECORDS && !sof && pos_q == RECORD_LAST
		&& done_q + 32'd1 == total_q;
	assign box_upd = acc && vec_out && vec != 2'd0;

	always_comb begin
		r0 = '0;
		r1 = '0;
		n  = 2'd0;
		if (restart_mid) begin
			r0.kind = KIND_TRUNC; r0.idx = done_q; r0.last = 1'b1; n = 2'd1;
		end else if (vec_out) begin
			r0.kind = {1'b0, vec}; r0.x = hx_q; r0.y = hy_q; r0.z = word;
			r0.idx = done_q; r0.last = 1'b1; n = 2'd1;
		end else if (fin) begin
			r0.kind = KIND_BOXMIN; r0.x = lo[31:0]; r0.y = lo[63:32];
			r0.z = lo[95:64]; r0.idx = total_q;
			r1.kind = KIND_BOXMAX; r1.x = hi[31:0]; r1.y = hi[63:32];
			r1.z = hi[95:64]; r1.idx = total_q; r1.last = 1'b1; n = 2'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0;
			part_q <= '0;
			hx_q <= '0;
			hy_q <= '0;
			total_q <= '0;
			done_q <= '0;
		end else if (acc) begin
			if (sof) begin
				part_q <= '0; hx_q <= '0; hy_q <= '0;
				total_q <= '0; done_q <= '0;
			end
			unique case (ph)
				PH_HEADER: begin
					if ((sof ? 7'd0 : pos_q) + 7'd1 >= HEADER_BYTES) begin
						phase_q <= PH_COUNT; pos_q <= '0;
					end else begin
						phase_q <= PH_HEADER; pos_q <= (sof ? 7'd0 : pos_q) + 7'd1;
					end
				end
				PH_COUNT: begin
					if (k == 2'd3) begin
						total_q <= word; done_q <= '0; pos_q <= '0;
						phase_q <= (word == 32'd0) ? PH_IDLE : PH_RECORDS;
					end else begin
						pos_q <= pos_q + 7'd1;
						if (k == 2'd0) part_q <= {16'd0, s_tdata};
						else if (k == 2'd1) part_q[15:8] <= s_tdata;
						else part_q[23:16] <= s_tdata;
					end
				end
				PH_RECORDS: begin
					if (pos_q < VEC_BYTES) begin
						pos_q <= pos_q + 7'd1;
						if (k == 2'd0) part_q <= {16'd0, s_tdata};
						else if (k == 2'd1) part_q[15:8] <= s_tdata;
						else if (k == 2'd2) part_q[23:16] <= s_tdata;
						else if (comp == 2'd0) hx_q <= word;
						else if (comp == 2'd1) hy_q <= word;
					end else if (pos_q < RECORD_LAST) begin
						pos_q <= pos_q + 7'd1;
					end else begin
						pos_q <= '0;
						done_q <= done_q + 32'd1;
						if (fin) phase_q <= PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	bssp_box u_box (
		.clk, .arst_n,
		.clr(acc && sof), .upd(box_upd),
		.vx(hx_q), .vy(hy_q), .vz(word),
		.lo, .hi
	);

	bssp_outq u_q (
		.clk, .arst_n,
		.push(acc), .n_in(n), .r0, .r1,
		.space(s_tready), .m_tvalid, .m_tready, .head
	);

	assign m_tdata = {head.idx, head.z, head.y, head.x};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;
endmodule

// ----- hdl/bssp_checker.sv -----
module bssp_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [2:0]   m_tuser,
	input logic         m_tlast
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 3'd7)
		else $error("bad kind");
	a_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == 3'd4 |-> !m_tlast)
		else $error("box minimum marked last");
	a_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == 3'd6 |-> m_tdata[95:0] == 96'd0)
		else $error("truncated result carries vector data");
endmodule

bind binary_stl_stream_parser_top bssp_checker u_chk (
	.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
	.m_tdata, .m_tuser, .m_tlast
);
